// ===== design/assert_macros.svh =====
// Assertion macros shared by the priority slot buffer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/psb_pkg.sv =====
// Package for the priority slot buffer: field widths, codes, FSM state type
// and the command/status structs between controller and datapath. No dependencies.
package psb_pkg;

  // Field widths of the request and response transactions.
  localparam int unsigned WAIT_W  = 32;
  localparam int unsigned SRC_W   = 4;
  localparam int unsigned NUM_W   = 16;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned ENTRY_W = WAIT_W + SRC_W + NUM_W;

  // Operation codes carried in the mode field.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_TAKE   = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_DRAIN,
    ST_TAKE,
    ST_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic req_ready;
    logic capture;
    logic do_insert;
    logic scan_rd;
    logic take;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_valid;
    logic req_mode;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/psb_req_if.sv =====
// Request channel interface of the priority slot buffer.
// Depends on psb_pkg for the field widths.
interface psb_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [psb_pkg::WAIT_W-1:0]  wait_time;
  logic [psb_pkg::SRC_W-1:0]   source_id;
  logic [psb_pkg::NUM_W-1:0]   request_number;

  modport source (output valid, mode, wait_time, source_id, request_number, input ready);
  modport sink   (input valid, mode, wait_time, source_id, request_number, output ready);
endinterface

// ===== design/psb_rsp_if.sv =====
// Response channel interface of the priority slot buffer.
// Depends on psb_pkg for the field widths.
interface psb_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [psb_pkg::IDX_W-1:0]   slot_index;
  logic [psb_pkg::WAIT_W-1:0]  out_wait_time;
  logic [psb_pkg::SRC_W-1:0]   out_source_id;
  logic [psb_pkg::NUM_W-1:0]   out_request_number;
  logic                        has_free;
  logic                        is_empty;

  modport source (output valid, ok, slot_index, out_wait_time, out_source_id,
                  out_request_number, has_free, is_empty, input ready);
  modport sink   (input valid, ok, slot_index, out_wait_time, out_source_id,
                  out_request_number, has_free, is_empty, output ready);
endinterface

// ===== design/psb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module psb_ram #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/psb_ctrl.sv =====
// Controller state machine of the priority slot buffer.
// Depends on psb_pkg for the state type and the command/status structs.
module psb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psb_pkg::sts_t  sts_i,
  output psb_pkg::cmd_t  cmd_o
);
  psb_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      psb_pkg::ST_IDLE: begin
        cmd_o.req_ready = 1'b1;
        if (sts_i.req_valid) begin
          cmd_o.capture = 1'b1;
          state_d = (sts_i.req_mode == psb_pkg::MODE_TAKE) ? psb_pkg::ST_SCAN
                                                           : psb_pkg::ST_INSERT;
        end
      end
      psb_pkg::ST_INSERT: begin
        cmd_o.do_insert = 1'b1;
        state_d = psb_pkg::ST_RESP;
      end
      psb_pkg::ST_SCAN: begin
        // One slot read is issued per cycle.
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = psb_pkg::ST_DRAIN;
        end
      end
      psb_pkg::ST_DRAIN: begin
        // The last read returns and is compared here.
        state_d = psb_pkg::ST_TAKE;
      end
      psb_pkg::ST_TAKE: begin
        cmd_o.take = 1'b1;
        state_d = psb_pkg::ST_RESP;
      end
      psb_pkg::ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = psb_pkg::ST_IDLE;
        end
      end
    endcase
  end
endmodule

// ===== design/psb_dpath.sv =====
// Datapath of the priority slot buffer: slot valid bits, entry RAM, scan
// compare and output register. Depends on psb_pkg, psb_req_if, psb_rsp_if, psb_ram.
module psb_dpath #(
  parameter int unsigned SLOTS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  psb_req_if.sink        req_i,
  psb_rsp_if.source      rsp_o,
  input  psb_pkg::cmd_t  cmd_i,
  output psb_pkg::sts_t  sts_o
);
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned KEY_W = psb_pkg::SRC_W + psb_pkg::NUM_W;

  // Captured request.
  logic [psb_pkg::WAIT_W-1:0] wait_q;
  logic [psb_pkg::SRC_W-1:0]  src_q;
  logic [psb_pkg::NUM_W-1:0]  num_q;

  // Slot occupancy.
  logic [SLOTS-1:0] valid_q, valid_d;

  // Scan address and read pipeline tag.
  logic [IW-1:0] scan_q;
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;

  // Result being built (best candidate during a take).
  logic                       res_ok_q;
  logic [IW-1:0]              res_idx_q;
  logic [psb_pkg::WAIT_W-1:0] res_wait_q;
  logic [psb_pkg::SRC_W-1:0]  res_src_q;
  logic [psb_pkg::NUM_W-1:0]  res_num_q;

  // Output register.
  logic                       out_vld_q;
  logic                       out_ok_q;
  logic [psb_pkg::IDX_W-1:0]  out_idx_q;
  logic [psb_pkg::WAIT_W-1:0] out_wait_q;
  logic [psb_pkg::SRC_W-1:0]  out_src_q;
  logic [psb_pkg::NUM_W-1:0]  out_num_q;
  logic                       out_free_q;
  logic                       out_empty_q;

  logic [IW-1:0]               ff_idx;
  logic                        any_free;
  logic [psb_pkg::ENTRY_W-1:0] rd_data;
  logic [psb_pkg::SRC_W-1:0]   rd_src;
  logic [psb_pkg::NUM_W-1:0]   rd_num;
  logic [psb_pkg::WAIT_W-1:0]  rd_wait;
  logic                        better;

  // Entry storage, one word per slot.
  psb_ram #(
    .WIDTH (psb_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.do_insert && any_free),
    .waddr_i (ff_idx),
    .wdata_i ({wait_q, src_q, num_q}),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (scan_q),
    .rdata_o (rd_data)
  );

  // Lowest-numbered free slot.
  always_comb begin
    ff_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        ff_idx = IW'(i);
      end
    end
  end
  assign any_free = |(~valid_q);

  // Split the returned entry and compare it with the current best.
  assign rd_num  = rd_data[psb_pkg::NUM_W-1:0];
  assign rd_src  = rd_data[KEY_W-1:psb_pkg::NUM_W];
  assign rd_wait = rd_data[psb_pkg::ENTRY_W-1:KEY_W];
  assign better  = rd_vld_q && valid_q[rd_idx_q] &&
                   (!res_ok_q || ({rd_src, rd_num} < {res_src_q, res_num_q}));

  // Occupancy update: set on insert, clear on take.
  always_comb begin
    valid_d = valid_q;
    if (cmd_i.do_insert && any_free) begin
      valid_d[ff_idx] = 1'b1;
    end
    if (cmd_i.take && res_ok_q) begin
      valid_d[res_idx_q] = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      scan_q    <= '0;
      rd_vld_q  <= 1'b0;
      res_ok_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.capture) begin
        scan_q   <= '0;
        res_ok_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          scan_q <= scan_q + 1'b1;
        end
        if ((cmd_i.do_insert && any_free) || better) begin
          res_ok_q <= 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_q;
    if (cmd_i.capture) begin
      wait_q     <= req_i.wait_time;
      src_q      <= req_i.source_id;
      num_q      <= req_i.request_number;
      res_idx_q  <= '0;
      res_wait_q <= '0;
      res_src_q  <= '0;
      res_num_q  <= '0;
    end else if (cmd_i.do_insert && any_free) begin
      res_idx_q <= ff_idx;
    end else if (better) begin
      res_idx_q  <= rd_idx_q;
      res_wait_q <= rd_wait;
      res_src_q  <= rd_src;
      res_num_q  <= rd_num;
    end
    if (cmd_i.load_out) begin
      out_ok_q    <= res_ok_q;
      out_idx_q   <= psb_pkg::IDX_W'(res_idx_q);
      out_wait_q  <= res_wait_q;
      out_src_q   <= res_src_q;
      out_num_q   <= res_num_q;
      out_free_q  <= |(~valid_q);
      out_empty_q <= ~|valid_q;
    end
  end

  // Status to the controller.
  assign sts_o.req_valid = req_i.valid;
  assign sts_o.req_mode  = req_i.mode;
  assign sts_o.scan_last = (scan_q == IW'(SLOTS - 1));
  assign sts_o.out_free  = !out_vld_q || rsp_o.ready;

  // Channel ports.
  assign req_i.ready              = cmd_i.req_ready;
  assign rsp_o.valid              = out_vld_q;
  assign rsp_o.ok                 = out_ok_q;
  assign rsp_o.slot_index         = out_idx_q;
  assign rsp_o.out_wait_time      = out_wait_q;
  assign rsp_o.out_source_id      = out_src_q;
  assign rsp_o.out_request_number = out_num_q;
  assign rsp_o.has_free           = out_free_q;
  assign rsp_o.is_empty           = out_empty_q;
endmodule

// ===== design/priority_slot_buffer_top.sv =====
// Priority slot buffer: SLOTS request slots. An insert transaction stores the
// request in the lowest-numbered free slot; a take transaction removes the
// request with the smallest source id, then smallest request number, then
// lowest slot. One transaction is handled at a time. An insert writes its slot
// directly; a take first runs a scan that reads the entry RAM one slot per
// cycle through its single read port.
// The result sits in an output register, so a stalled consumer delays only the
// next transaction's result. Slot entries need no clearing pass after reset:
// occupancy is held in SLOTS valid flip-flops that reset clears.
// Depends on psb_pkg, psb_req_if, psb_rsp_if, psb_ram, psb_ctrl, psb_dpath
// and assert_macros.svh.
`include "assert_macros.svh"

module priority_slot_buffer_top #(
  parameter int unsigned SLOTS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psb_req_if.sink    req_i,
  psb_rsp_if.source  rsp_o
);
  psb_pkg::cmd_t cmd;
  psb_pkg::sts_t sts;

  // Sequencing.
  psb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Storage, selection and output register.
  psb_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  // A transaction is accepted only when the previous one has been finished.
  `PSB_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready, "request accepted while busy")
  // Loading the result makes it visible on the response channel.
  `PSB_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, cmd.load_out, rsp_o.valid, "loaded result not presented")
  // A buffer cannot be both full and empty.
  `PSB_ASSERT_IMPL(a_flags_consistent, clk_i, rst_ni, rsp_o.valid, rsp_o.has_free || !rsp_o.is_empty, "full and empty at once")
  // A failed result carries zero request fields.
  `PSB_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, rsp_o.valid && !rsp_o.ok, (rsp_o.slot_index == 0) && (rsp_o.out_wait_time == 0) && (rsp_o.out_source_id == 0) && (rsp_o.out_request_number == 0), "failed result carries data")
endmodule

// ===== bench/psb_outcome_checker.sv =====
// Checker for the priority slot buffer: watches the request and response channels,
// predicts each response from its own copy of the slots and compares field by field.
// Depends on psb_pkg, psb_req_if and psb_rsp_if.
`timescale 1ns / 100ps

module psb_outcome_checker
  import psb_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  psb_req_if          req_i,
  psb_rsp_if          rsp_i,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);

  // One stored request as the buffer holds it.
  typedef struct packed {
    logic [WAIT_W-1:0] wait_time;
    logic [SRC_W-1:0]  source_id;
    logic [NUM_W-1:0]  request_number;
  } held_req_t;

  // One response transaction as the buffer should return it.
  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  slot_index;
    logic [WAIT_W-1:0] out_wait_time;
    logic [SRC_W-1:0]  out_source_id;
    logic [NUM_W-1:0]  out_request_number;
    logic              has_free;
    logic              is_empty;
  } slot_outcome_t;

  logic          occupied [SLOTS];
  held_req_t     held     [SLOTS];
  slot_outcome_t outcome_q[$];
  slot_outcome_t predicted;
  slot_outcome_t want;
  int unsigned   mismatches;

  // Apply one request to the shadow slots and return the response it should produce.
  function automatic slot_outcome_t apply_slot_request(logic mode, logic [WAIT_W-1:0] wt,
                                                       logic [SRC_W-1:0] src,
                                                       logic [NUM_W-1:0] num);
    slot_outcome_t res;
    int unsigned   best;
    logic          found;
    res   = '0;
    best  = 0;
    found = 1'b0;
    if (mode == MODE_INSERT) begin
      // Lowest-numbered free slot takes the request; a full buffer stores nothing.
      for (int unsigned i = 0; i < SLOTS; i++) begin
        if (!found && !occupied[i]) begin
          occupied[i]    = 1'b1;
          held[i]        = '{wait_time: wt, source_id: src, request_number: num};
          res.ok         = 1'b1;
          res.slot_index = IDX_W'(i);
          found          = 1'b1;
        end
      end
    end else begin
      // Smallest source id wins, then smallest request number; a strict compare
      // leaves the lowest slot in front when both are equal.
      for (int unsigned i = 0; i < SLOTS; i++) begin
        if (occupied[i]) begin
          if (!found) begin
            best  = i;
            found = 1'b1;
          end else if (held[i].source_id < held[best].source_id ||
                       (held[i].source_id == held[best].source_id &&
                        held[i].request_number < held[best].request_number)) begin
            best = i;
          end
        end
      end
      if (found) begin
        res.ok                 = 1'b1;
        res.slot_index         = IDX_W'(best);
        res.out_wait_time      = held[best].wait_time;
        res.out_source_id      = held[best].source_id;
        res.out_request_number = held[best].request_number;
        occupied[best]         = 1'b0;
      end
    end
    // Occupancy flags after the step.
    res.has_free = 1'b0;
    res.is_empty = 1'b1;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (occupied[i]) res.is_empty = 1'b0;
      else res.has_free = 1'b1;
    end
    return res;
  endfunction

  // Compare one response field and count a mismatch.
  task automatic compare_field(string name, logic [WAIT_W-1:0] exp_v, logic [WAIT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  // Predict on every accepted request, compare on every accepted response.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < SLOTS; i++) begin
        occupied[i] = 1'b0;
        held[i]     = '0;
      end
      outcome_q.delete();
      pending_o    <= 0;
      mismatches_o <= mismatches;
    end else begin
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        predicted = apply_slot_request(req_i.mode, req_i.wait_time, req_i.source_id,
                                       req_i.request_number);
        outcome_q = {outcome_q, predicted};
      end
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (outcome_q.size() == 0) begin
          $error("response transaction with no request outstanding");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          compare_field("ok", WAIT_W'(want.ok), WAIT_W'(rsp_i.ok));
          compare_field("slot_index", WAIT_W'(want.slot_index), WAIT_W'(rsp_i.slot_index));
          compare_field("out_wait_time", want.out_wait_time, rsp_i.out_wait_time);
          compare_field("out_source_id", WAIT_W'(want.out_source_id),
                        WAIT_W'(rsp_i.out_source_id));
          compare_field("out_request_number", WAIT_W'(want.out_request_number),
                        WAIT_W'(rsp_i.out_request_number));
          compare_field("has_free", WAIT_W'(want.has_free), WAIT_W'(rsp_i.has_free));
          compare_field("is_empty", WAIT_W'(want.is_empty), WAIT_W'(rsp_i.is_empty));
        end
      end
      pending_o    <= outcome_q.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

// ===== bench/priority_slot_buffer_top_tb.sv =====
// Testbench top for the priority slot buffer: drives directed and random request
// transactions, stalls the response side and gives the verdict.
// Depends on psb_pkg, psb_req_if, psb_rsp_if, the block and psb_outcome_checker.
`timescale 1ns / 100ps

module priority_slot_buffer_top_tb;
  import psb_pkg::*;

  localparam int unsigned SLOTS        = 8;
  localparam int unsigned RANDOM_ITEMS = 500;
  // Watchdog limit for the whole run, with room for take scans plus long stalls.
  localparam int unsigned CYCLE_LIMIT  = 400_000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned req_idle_pct;
  int unsigned rsp_idle_pct;
  int unsigned cycles;

  psb_req_if req_if ();
  psb_rsp_if rsp_if ();

  priority_slot_buffer_top #(
    .SLOTS (SLOTS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  psb_outcome_checker #(
    .SLOTS (SLOTS)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Response side stalls at the current rate.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("priority_slot_buffer_top_tb failed");
      $finish;
    end
  end

  // Send one request transaction, with random idle cycles ahead of it.
  task automatic send_request(logic mode, logic [WAIT_W-1:0] wt, logic [SRC_W-1:0] src,
                              logic [NUM_W-1:0] num);
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.mode           <= mode;
    req_if.wait_time      <= wt;
    req_if.source_id      <= src;
    req_if.request_number <= num;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  // Hold the request side idle until every outstanding response has come back.
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Random requests with a shifting insert/take mix so the buffer fills and empties.
  task automatic send_random_requests(int unsigned count);
    int unsigned       insert_pct;
    logic [WAIT_W-1:0] wt;
    logic [SRC_W-1:0]  src;
    logic [NUM_W-1:0]  num;
    insert_pct = 50;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 20;
          1:       insert_pct = 50;
          default: insert_pct = 80;
        endcase
      end
      case ($urandom_range(5))
        0:       wt = '0;
        1:       wt = '1;
        default: wt = $urandom;
      endcase
      // Narrow ranges make ties on source id and request number common.
      case ($urandom_range(3))
        0, 1:    src = SRC_W'($urandom_range(15));
        2:       src = SRC_W'($urandom_range(1));
        default: src = 4'd7;
      endcase
      if ($urandom_range(1)) num = NUM_W'($urandom);
      else num = NUM_W'($urandom_range(3));
      send_request(($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_TAKE, wt, src, num);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    req_idle_pct          = 13;
    rsp_idle_pct          = 74;
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.mode           = MODE_INSERT;
    req_if.wait_time      = '0;
    req_if.source_id      = '0;
    req_if.request_number = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: take from empty, fill with extreme fields and ties, insert into
    // a full buffer, then drain in priority order and take from empty again.
    send_request(MODE_TAKE,   32'hFFFF_FFFF, 4'hF, 16'hFFFF);
    send_request(MODE_INSERT, 32'h0000_0000, 4'hF, 16'hFFFF);
    send_request(MODE_INSERT, 32'hFFFF_FFFF, 4'h0, 16'h0000);
    send_request(MODE_INSERT, 32'hAAAA_AAAA, 4'h3, 16'h0005);
    send_request(MODE_INSERT, 32'h5555_5555, 4'h3, 16'h0005);
    send_request(MODE_INSERT, 32'h1234_5678, 4'h3, 16'h0004);
    send_request(MODE_INSERT, 32'hFFFF_FFFF, 4'hF, 16'h0000);
    send_request(MODE_INSERT, 32'h0000_0001, 4'h0, 16'h0000);
    send_request(MODE_INSERT, 32'h8000_0000, 4'h8, 16'h8000);
    send_request(MODE_INSERT, 32'hDEAD_BEEF, 4'h1, 16'h0001);
    repeat (SLOTS) send_request(MODE_TAKE, 32'h0, 4'h0, 16'h0);
    send_request(MODE_TAKE, 32'h0, 4'h0, 16'h0);
    drain_responses();

    // Random: sender idles rarely and receiver often, then swapped, then neither.
    send_random_requests(RANDOM_ITEMS);
    drain_responses();
    req_idle_pct = 74;
    rsp_idle_pct = 13;
    send_random_requests(RANDOM_ITEMS);
    drain_responses();
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    send_random_requests(RANDOM_ITEMS);
    drain_responses();

    // Let any stray response show up before the verdict.
    repeat (2 * SLOTS + 8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("priority_slot_buffer_top_tb passed");
    end else begin
      $display("priority_slot_buffer_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== priority_slot_buffer_top.f =====
+incdir+design
design/psb_pkg.sv
design/psb_req_if.sv
design/psb_rsp_if.sv
design/psb_ram.sv
design/psb_ctrl.sv
design/psb_dpath.sv
design/priority_slot_buffer_top.sv
bench/psb_outcome_checker.sv
bench/priority_slot_buffer_top_tb.sv
